@@ design/burst_detector_window_mean_unit_defines.svh @@
// Assertion macros for the burst detector window mean unit.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef BURST_DETECTOR_WINDOW_MEAN_UNIT_DEFINES_SVH
`define BURST_DETECTOR_WINDOW_MEAN_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define BDWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BDWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/bdwm_pkg.sv @@
// Package for the burst detector window mean unit.
// Holds defaults, register indexes, divider constants and the sequencer states.
package bdwm_pkg;

  localparam int unsigned DEF_WINDOW = 16;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned THRESH_W = 32;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENTER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXIT  = CFG_IDX_W'(1);

  localparam logic [THRESH_W-1:0] ENTER_RESET = THRESH_W'(20);
  localparam logic [THRESH_W-1:0] EXIT_RESET  = THRESH_W'(35);

  // Divider retires DIGIT_BITS quotient bits per cycle.
  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned DIV_STEPS  = TIME_W / DIGIT_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP_NEW,
    ST_DROP_A,
    ST_DROP_B,
    ST_DROP_C,
    ST_ADD,
    ST_DIV,
    ST_DECIDE
  } bdwm_state_e;

endpackage

@@ design/bdwm_in_if.sv @@
// Input channel carrying one arrival timestamp per word.
// Depends on bdwm_pkg for the field width.
interface bdwm_in_if
  import bdwm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] arrival_time;

  modport source (output valid, output arrival_time, input ready);
  modport sink   (input valid, input arrival_time, output ready);
endinterface

@@ design/bdwm_out_if.sv @@
// Result channel: burst flag, mean gap, burst entry time and tick count.
// Depends on bdwm_pkg for the field widths.
interface bdwm_out_if
  import bdwm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              burst_active;
  logic [TIME_W-1:0] mean_gap;
  logic [TIME_W-1:0] entry_time;
  logic [TICK_W-1:0] tick_count;

  modport source (output valid, output burst_active, output mean_gap,
                  output entry_time, output tick_count, input ready);
  modport sink   (input valid, input burst_active, input mean_gap,
                  input entry_time, input tick_count, output ready);
endinterface

@@ design/burst_detector_window_mean_unit.sv @@
// Burst detector over a sliding window of arrival timestamps.
// Channels: in_i takes one timestamp word, out_o returns one result word per
// input word, both valid/ready. A write port sets the two thresholds.
// Each word walks a sequencer: one 64-bit add/subtract unit computes the
// newest gap and drops the oldest one, reading the timestamp ring one entry
// a cycle; then a divider retires 4 quotient bits a cycle to form the mean
// gap, which is compared against the thresholds.
// The first word after reset goes straight to the decide state; later words
// walk the gap state, the drop states once the window is full, add and divide.
// in_i.ready is high only in the idle state, so a new word is not taken until
// the last one has left the decide state.
// The result sits in an output register: a new word may be accepted while it
// waits, but the next result is held back until out_o.ready takes the old one.
// Reset empties the window, clears the sum and burst state and loads the
// thresholds with 20 and 35. The ring memory is not cleared; entries are
// only read after they were written.
`include "burst_detector_window_mean_unit_defines.svh"

module burst_detector_window_mean_unit
  import bdwm_pkg::*;
#(
  parameter int unsigned WINDOW = DEF_WINDOW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [THRESH_W-1:0]  cfg_wdata_i,
  bdwm_in_if.sink              in_i,
  bdwm_out_if.source           out_o
);

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FW = $clog2(WINDOW + 1);
  localparam int unsigned DW = $clog2(WINDOW);
  localparam int unsigned RW = DW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW - 1);
  localparam logic [FW-1:0] FULL     = FW'(WINDOW);

  bdwm_state_e state_q, state_d;

  logic [THRESH_W-1:0] enter_q, exit_q;

  logic [TIME_W-1:0] ring_mem [WINDOW];
  logic [TIME_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [TIME_W-1:0] mem_wdata;

  logic [AW-1:0]     wp_q, wp_next, wp_prev;
  logic [FW-1:0]     fill_q;
  logic [TIME_W-1:0] sum_q;
  logic [TIME_W-1:0] t_q, gap_q, tmp_q;
  logic              first_q;

  logic [TIME_W-1:0]    quo_q, quo_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DW-1:0]        divisor;

  logic              burst_q;
  logic [TIME_W-1:0] start_q;
  logic [TICK_W-1:0] ticks_q;

  logic              burst_d;
  logic [TIME_W-1:0] start_d;
  logic [TICK_W-1:0] ticks_d;

  logic              out_valid_q;
  logic              out_burst_q;
  logic [TIME_W-1:0] out_mean_q, out_entry_q;
  logic [TICK_W-1:0] out_ticks_q;

  logic              in_acc, out_free, load_out;
  logic [TIME_W-1:0] alu_a, alu_b, alu_y;
  logic              alu_sub;

  assign wp_next = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
  assign wp_prev = (wp_q == '0) ? LAST_IDX : wp_q - 1'b1;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign load_out   = (state_q == ST_DECIDE) && out_free;

  // Shared add/subtract unit
  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  always_comb begin
    state_d   = state_q;
    rd_addr   = wp_q;
    mem_we    = 1'b0;
    mem_wdata = t_q;
    alu_a     = sum_q;
    alu_b     = gap_q;
    alu_sub   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_addr   = wp_prev;
        mem_wdata = in_i.arrival_time;
        if (in_acc) begin
          if (fill_q == '0) begin
            mem_we  = 1'b1;
            state_d = ST_DECIDE;
          end else begin
            state_d = ST_GAP_NEW;
          end
        end
      end
      ST_GAP_NEW: begin
        rd_addr = wp_next;
        alu_a   = t_q;
        alu_b   = rd_data_q;
        alu_sub = 1'b1;
        state_d = (fill_q == FULL) ? ST_DROP_A : ST_ADD;
      end
      ST_DROP_A: begin
        rd_addr = wp_q;
        state_d = ST_DROP_B;
      end
      ST_DROP_B: begin
        alu_a   = tmp_q;
        alu_b   = rd_data_q;
        alu_sub = 1'b1;
        state_d = ST_DROP_C;
      end
      ST_DROP_C: begin
        alu_a   = sum_q;
        alu_b   = tmp_q;
        alu_sub = 1'b1;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        mem_we  = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Timestamp ring: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wp_q] <= mem_wdata;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_q <= ENTER_RESET;
      exit_q  <= EXIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ENTER: enter_q <= cfg_wdata_i;
        REG_EXIT:  exit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Divider: restoring, DIGIT_BITS steps per cycle on a narrow remainder
  assign divisor = DW'(fill_q - 1'b1);

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < DIGIT_BITS; k++) begin
      rem_d = {rem_d[RW-2:0], quo_d[TIME_W-1]};
      quo_d = {quo_d[TIME_W-2:0], 1'b0};
      if (rem_d >= {1'b0, divisor}) begin
        rem_d    = rem_d - {1'b0, divisor};
        quo_d[0] = 1'b1;
      end
    end
  end

  // Burst decision on the finished mean
  always_comb begin
    burst_d = burst_q;
    start_d = start_q;
    ticks_d = ticks_q;
    if (!first_q) begin
      if (!burst_q && (quo_q < {{(TIME_W-THRESH_W){1'b0}}, enter_q})) begin
        burst_d = 1'b1;
        start_d = t_q;
        ticks_d = TICK_W'(1);
      end else if (burst_q) begin
        if (ticks_q != '1) begin
          ticks_d = ticks_q + 1'b1;
        end
        if (quo_q > {{(TIME_W-THRESH_W){1'b0}}, exit_q}) begin
          burst_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      burst_q <= 1'b0;
      start_q <= '0;
      ticks_q <= '0;
      cnt_q   <= '0;
      first_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            first_q <= (fill_q == '0);
            if (fill_q == '0) begin
              wp_q   <= wp_next;
              fill_q <= FW'(1);
            end
          end
        end
        ST_DROP_C: begin
          sum_q <= alu_y;
        end
        ST_ADD: begin
          sum_q <= alu_y;
          wp_q  <= wp_next;
          cnt_q <= '0;
          if (fill_q != FULL) begin
            fill_q <= fill_q + 1'b1;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
        end
        ST_DECIDE: begin
          if (out_free) begin
            burst_q <= burst_d;
            start_q <= start_d;
            ticks_q <= ticks_d;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath words, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          t_q   <= in_i.arrival_time;
          quo_q <= '0;
        end
      end
      ST_GAP_NEW: gap_q <= alu_y;
      ST_DROP_A:  tmp_q <= rd_data_q;
      ST_DROP_B:  tmp_q <= alu_y;
      ST_ADD: begin
        quo_q <= alu_y;
        rem_q <= '0;
      end
      ST_DIV: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_burst_q <= burst_d;
      out_mean_q  <= quo_q;
      out_entry_q <= start_d;
      out_ticks_q <= ticks_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.burst_active = out_burst_q;
  assign out_o.mean_gap     = out_mean_q;
  assign out_o.entry_time   = out_entry_q;
  assign out_o.tick_count   = out_ticks_q;

  `BDWM_ASSERT(a_fill_bound, fill_q <= FULL, "fill count beyond window")
  `BDWM_ASSERT_IMP(a_burst_ticks, burst_q, ticks_q != '0, "burst active with zero ticks")
  `BDWM_ASSERT_IMP(a_out_from_decide, $rose(out_valid_q), $past(state_q == ST_DECIDE),
    "result raised outside decide state")
  `BDWM_ASSERT_IMP(a_first_empty, in_acc && (fill_q == '0), wp_q == '0,
    "write pointer moved while window empty")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for burst_detector_window_mean_unit: timestamp words in,
// burst results out, with each result compared to a behavioral window-mean predictor.
// Depends on bdwm_pkg, bdwm_in_if and bdwm_out_if from the design folder.
module tb_top;
  import bdwm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 66;
  localparam int unsigned NUM_DIRECTED = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic              burst_active;
    logic [TIME_W-1:0] mean_gap;
    logic [TIME_W-1:0] entry_time;
    logic [TICK_W-1:0] tick_count;
  } burst_result_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic              typed;
    burst_result_t     res;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [THRESH_W-1:0]  cfg_wdata_i;

  bdwm_in_if  in_ch ();
  bdwm_out_if out_ch ();

  burst_detector_window_mean_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Predictor state, a private copy of the block's window and burst tracking.
  logic [TIME_W-1:0]   time_ring [DEF_WINDOW];
  logic [3:0]          wr_ptr;
  logic [4:0]          fill_cnt;
  logic [TIME_W-1:0]   gap_sum;
  logic                pred_burst;
  logic [TIME_W-1:0]   burst_entry;
  logic [TICK_W-1:0]   burst_ticks;
  logic [THRESH_W-1:0] enter_thr;
  logic [THRESH_W-1:0] exit_thr;

  burst_result_t expected_results[$];
  int unsigned   error_count;
  int unsigned   words_sent;
  int unsigned   results_checked;
  int unsigned   burst_results;
  int unsigned   quiet_cycles;
  bit            steady;
  bit            hold_request;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic burst_result_t predict_window_mean(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] newest_gap;
    logic [TIME_W-1:0] mean;
    burst_result_t     r;
    mean = '0;
    if (fill_cnt == 5'd0) begin
      time_ring[wr_ptr] = t;
      wr_ptr = wr_ptr + 4'd1;
      fill_cnt = 5'd1;
    end else begin
      newest_gap = t - time_ring[wr_ptr - 4'd1];
      if (fill_cnt >= 5'(DEF_WINDOW)) begin
        fill_cnt = 5'(DEF_WINDOW);
        // drop the gap between the two oldest stamps
        gap_sum = gap_sum - (time_ring[wr_ptr + 4'd1] - time_ring[wr_ptr]);
      end else begin
        fill_cnt = fill_cnt + 5'd1;
      end
      gap_sum = gap_sum + newest_gap;
      time_ring[wr_ptr] = t;
      wr_ptr = wr_ptr + 4'd1;
      mean = gap_sum / TIME_W'(fill_cnt - 5'd1);
      if (!pred_burst && mean < TIME_W'(enter_thr)) begin
        pred_burst = 1'b1;
        burst_entry = t;
        burst_ticks = TICK_W'(1);
      end else if (pred_burst) begin
        if (burst_ticks != '1) burst_ticks = burst_ticks + TICK_W'(1);
        if (mean > TIME_W'(exit_thr)) pred_burst = 1'b0;
      end
    end
    r.burst_active = pred_burst;
    r.mean_gap     = mean;
    r.entry_time   = burst_entry;
    r.tick_count   = burst_ticks;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_upto(input logic [TIME_W-1:0] hi);
    logic [TIME_W-1:0] r;
    r = {$urandom, $urandom};
    if (hi == '1) return r;
    return r % (hi + TIME_W'(1));
  endfunction

  // Called at a falling edge; returns at a falling edge after the word is taken.
  task automatic send_word(input logic [TIME_W-1:0] t, input logic typed,
                           input burst_result_t typed_res);
    burst_result_t want;
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.arrival_time <= t;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    want = predict_window_mean(t);
    if (typed) want = typed_res;
    expected_results.push_back(want);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THRESH_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_ENTER: enter_thr = val;
      REG_EXIT:  exit_thr = val;
      default: ;
    endcase
  endtask

  // Drop valid and wait until every result is back and the sequencer is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned   hold_left;
    burst_result_t got;
    burst_result_t want;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 31);
      end
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.burst_active, out_ch.mean_gap, out_ch.entry_time, out_ch.tick_count};
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing outstanding: burst=%0b mean=%0d entry=%0d ticks=%0d",
                   $time, got.burst_active, got.mean_gap, got.entry_time, got.tick_count);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.burst_active) burst_results++;
          if (got.burst_active !== want.burst_active) begin
            $display("%0t: burst_active expected %0b actual %0b",
                     $time, want.burst_active, got.burst_active);
            error_count++;
          end
          if (got.mean_gap !== want.mean_gap) begin
            $display("%0t: mean_gap expected %0d actual %0d", $time, want.mean_gap, got.mean_gap);
            error_count++;
          end
          if (got.entry_time !== want.entry_time) begin
            $display("%0t: entry_time expected %0d actual %0d",
                     $time, want.entry_time, got.entry_time);
            error_count++;
          end
          if (got.tick_count !== want.tick_count) begin
            $display("%0t: tick_count expected %0d actual %0d",
                     $time, want.tick_count, got.tick_count);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t           directed_rows [NUM_DIRECTED];
    logic [THRESH_W-1:0] enter_set [NUM_PHASES];
    logic [THRESH_W-1:0] exit_set  [NUM_PHASES];
    logic [TIME_W-1:0]   cur_time;
    logic [TIME_W-1:0]   fast_hi;
    logic [TIME_W-1:0]   slow_lo;
    logic                fast_mode;
    int unsigned         seg_left;
    int unsigned         roll;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = REG_ENTER;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.arrival_time = '0;
    steady             = 1'b0;
    hold_request       = 1'b0;
    error_count        = 0;
    words_sent         = 0;
    results_checked    = 0;
    burst_results      = 0;
    quiet_cycles       = 0;

    wr_ptr      = '0;
    fill_cnt    = '0;
    gap_sum     = '0;
    pred_burst  = 1'b0;
    burst_entry = '0;
    burst_ticks = '0;
    enter_thr   = ENTER_RESET;
    exit_thr    = EXIT_RESET;

    // Typed rows: first word, first burst, max stamp forcing an exit, and a
    // backward step whose wrapped gap brings the sum back to zero.
    // The rest run past a full window so the oldest gap starts dropping.
    directed_rows = '{
      '{64'd0,    1'b1, '{1'b0, 64'd0, 64'd0, 32'd0}},
      '{64'd10,   1'b1, '{1'b1, 64'd10, 64'd10, 32'd1}},
      '{64'd10,   1'b1, '{1'b1, 64'd5, 64'd10, 32'd2}},
      '{'1,       1'b1, '{1'b0, 64'h5555_5555_5555_5555, 64'd10, 32'd3}},
      '{64'd0,    1'b1, '{1'b1, 64'd0, 64'd0, 32'd1}},
      '{64'd100,  1'b0, '0},
      '{64'd120,  1'b0, '0},
      '{64'd121,  1'b0, '0},
      '{64'd122,  1'b0, '0},
      '{64'd1000, 1'b0, '0},
      '{64'd1000, 1'b0, '0},
      '{64'd1030, 1'b0, '0},
      '{64'd1060, 1'b0, '0},
      '{64'd1090, 1'b0, '0},
      '{64'd1120, 1'b0, '0},
      '{64'd1150, 1'b0, '0},
      '{64'd1180, 1'b0, '0},
      '{64'd1190, 1'b0, '0},
      '{64'd1195, 1'b0, '0},
      '{64'd1196, 1'b0, '0}
    };

    enter_set[0] = '0;        exit_set[0] = '1;
    enter_set[1] = '1;        exit_set[1] = '1;
    enter_set[2] = 32'd100;   exit_set[2] = 32'd400;
    enter_set[3] = 32'd1000;  exit_set[3] = 32'd1000;
    enter_set[4] = 32'd50;    exit_set[4] = '0;
    enter_set[5] = '0;        exit_set[5] = '0;
    for (int p = 6; p < NUM_PHASES; p++) begin
      enter_set[p] = $urandom_range(1, 5000);
      exit_set[p]  = enter_set[p] + $urandom_range(0, 5000);
    end

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(directed_rows[i].arrival, directed_rows[i].typed, directed_rows[i].res);
    end
    cur_time = directed_rows[NUM_DIRECTED-1].arrival;

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == 0) begin
        // spare indexes must leave both thresholds alone
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
      end
      write_reg(REG_ENTER, enter_set[p]);
      write_reg(REG_EXIT, exit_set[p]);
      steady = (p == 1);
      if (p == 2) hold_request = 1'b1;

      fast_hi  = (enter_thr == '0) ? TIME_W'(8) : TIME_W'(enter_thr) * 2;
      slow_lo  = TIME_W'(exit_thr);
      seg_left = 0;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (seg_left == 0) begin
          fast_mode = 1'($urandom_range(0, 1));
          seg_left  = $urandom_range(4, 30);
        end
        seg_left--;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          cur_time = {$urandom, $urandom};
        end else if (roll < 5) begin
          cur_time = cur_time - TIME_W'($urandom_range(0, 64));
        end else if (fast_mode) begin
          cur_time = cur_time + rand_upto(fast_hi);
        end else begin
          cur_time = cur_time + slow_lo + rand_upto(slow_lo * 2 + TIME_W'(8));
        end
        send_word(cur_time, 1'b0, '0);
      end
      steady = 1'b0;
    end

    settle();
    $display("Sent %0d timestamp words over %0d threshold settings plus the reset values;",
             words_sent, NUM_PHASES);
    $display("checked %0d results, %0d of them inside a burst.", results_checked, burst_results);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
